### rtl/hash_key_id_assigner_macros.svh
// assertion macros shared by the hash key id assigner modules
// expects a clock aclk and an active-low reset aresetn in the using module
`ifndef HASH_KEY_ID_ASSIGNER_MACROS_SVH
`define HASH_KEY_ID_ASSIGNER_MACROS_SVH

// same-cycle implication
`define HKA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hash_key_id_assigner: assertion failed");

// next-cycle implication
`define HKA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hash_key_id_assigner: assertion failed");

`endif

### rtl/hka_pkg.sv
// shared types, constants and the base64 decode function of the hash key id assigner
// no dependencies
`default_nettype none

package hka_pkg;

    localparam int TABLE_BITS = 10;
    localparam int SLOTS      = 1 << TABLE_BITS;
    localparam int ID_W       = TABLE_BITS + 1;
    localparam int KEY_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int NUM_CHARS  = 11;
    localparam int UID_W      = 10;
    localparam int B64_W      = 6;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;

    localparam logic [B64_W-1:0] B64_LOWER_BASE = 6'd26;
    localparam logic [B64_W-1:0] B64_DIGIT_BASE = 6'd52;
    localparam logic [B64_W-1:0] B64_PLUS       = 6'd62;
    localparam logic [B64_W-1:0] B64_SLASH      = 6'd63;

    typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] char_vec_t;

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic advance;
        logic do_insert;
        logic do_hit;
        logic do_full;
    } hka_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic id_empty;
        logic key_match;
        logic probe_last;
        logic out_free;
    } hka_sts_t;

    function automatic logic [B64_W-1:0] b64_value(input logic [CHAR_W-1:0] c);
        logic [B64_W-1:0] v;
        v = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = B64_W'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = B64_W'(c - CHAR_LOWER_A) + B64_LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = B64_W'(c - CHAR_DIGIT_0) + B64_DIGIT_BASE;
        end else if (c == CHAR_PLUS) begin
            v = B64_PLUS;
        end else if (c == CHAR_SLASH) begin
            v = B64_SLASH;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/hash_key_id_assigner.sv
// hash key id assigner: usage notes
// Input channel s_*: eleven base64 character bytes of a hash per item. Result
// channel m_*: one item per input with user_id, is_new and table_full.
// Each key is decoded to 64 bits and looked up in an open-addressing table of
// 2^TABLE_BITS slots by double hashing; a new key gets the next sequential id.
// Steps: the item is taken in the idle state, then each probe is a read step
// (registered read of the key and id stores) followed by a compare step. The
// result is registered at the end of the last compare, after which the block
// returns to idle; it takes no new item while one is still being probed. At
// most 2^TABLE_BITS probes are made before a key is reported as table_full.
// Reset: the id store is swept to empty, one slot a cycle, all 2^TABLE_BITS
// slots (1024 at the default size) with s_ready low; entry count clears.
// Stall: the result register holds while m_ready is low and the next item is
// still taken; its result waits in the compare step until the register frees.
// Depends on hka_pkg, hka_ctrl and hka_datapath.
`default_nettype none

module hash_key_id_assigner import hka_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_char_0,
    input  wire logic [CHAR_W-1:0] s_char_1,
    input  wire logic [CHAR_W-1:0] s_char_2,
    input  wire logic [CHAR_W-1:0] s_char_3,
    input  wire logic [CHAR_W-1:0] s_char_4,
    input  wire logic [CHAR_W-1:0] s_char_5,
    input  wire logic [CHAR_W-1:0] s_char_6,
    input  wire logic [CHAR_W-1:0] s_char_7,
    input  wire logic [CHAR_W-1:0] s_char_8,
    input  wire logic [CHAR_W-1:0] s_char_9,
    input  wire logic [CHAR_W-1:0] s_char_10,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [UID_W-1:0]  m_user_id,
    output logic                   m_is_new,
    output logic                   m_table_full
);

    char_vec_t chars;
    hka_cmd_t  cmd;
    hka_sts_t  sts;

    assign chars[0]  = s_char_0;
    assign chars[1]  = s_char_1;
    assign chars[2]  = s_char_2;
    assign chars[3]  = s_char_3;
    assign chars[4]  = s_char_4;
    assign chars[5]  = s_char_5;
    assign chars[6]  = s_char_6;
    assign chars[7]  = s_char_7;
    assign chars[8]  = s_char_8;
    assign chars[9]  = s_char_9;
    assign chars[10] = s_char_10;

    hka_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    hka_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_chars      (chars),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_user_id    (m_user_id),
        .m_is_new     (m_is_new),
        .m_table_full (m_table_full)
    );

endmodule

`default_nettype wire

### rtl/hka_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module hka_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/hka_datapath.sv
// key decode, probe address registers, key and id stores, entry counter and result register
// depends on hka_pkg and hka_ram
`default_nettype none

module hka_datapath import hka_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire char_vec_t        s_chars,
    input  wire hka_cmd_t         cmd,
    output hka_sts_t              sts,
    input  wire logic             m_ready,
    output logic                  m_valid,
    output logic      [UID_W-1:0] m_user_id,
    output logic                  m_is_new,
    output logic                  m_table_full
);

    logic [KEY_W-1:0]      key_dec;
    logic [B64_W-1:0]      last_val;
    logic [KEY_W-1:0]      key_reg;
    logic [TABLE_BITS-1:0] slot_reg;
    logic [TABLE_BITS-1:0] stride_reg;
    logic [TABLE_BITS-1:0] probe_cnt_reg;
    logic [TABLE_BITS-1:0] clr_addr_reg;
    logic [ID_W-1:0]       entry_count_reg;
    logic                  m_valid_reg;
    logic [UID_W-1:0]      m_user_id_reg;
    logic                  m_is_new_reg;
    logic                  m_table_full_reg;

    logic [KEY_W-1:0]      key_rdata;
    logic [ID_W-1:0]       id_rdata;
    logic                  id_we;
    logic [TABLE_BITS-1:0] id_waddr;
    logic [ID_W-1:0]       id_wdata;

    // ten full characters, then the top four bits of the last one
    always_comb begin
        key_dec  = '0;
        last_val = b64_value(s_chars[NUM_CHARS-1]);
        for (int k = 0; k < NUM_CHARS - 1; k++) begin
            key_dec[KEY_W-1-B64_W*k -: B64_W] = b64_value(s_chars[k]);
        end
        key_dec[3:0] = last_val[B64_W-1:2];
    end

    assign id_we    = cmd.clear_wr | cmd.do_insert;
    assign id_waddr = cmd.clear_wr ? clr_addr_reg : slot_reg;
    assign id_wdata = cmd.clear_wr ? '0 : entry_count_reg + ID_W'(1);

    hka_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.do_insert),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (slot_reg),
        .rdata (key_rdata)
    );

    hka_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
        .aclk  (aclk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (slot_reg),
        .rdata (id_rdata)
    );

    // probe registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg       <= key_dec;
            slot_reg      <= key_dec[TABLE_BITS-1:0];
            stride_reg    <= key_dec[2*TABLE_BITS-1:TABLE_BITS] | TABLE_BITS'(1);
            probe_cnt_reg <= '0;
        end else if (cmd.advance) begin
            slot_reg      <= slot_reg + stride_reg;
            probe_cnt_reg <= probe_cnt_reg + TABLE_BITS'(1);
        end
    end

    // control counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg    <= '0;
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + TABLE_BITS'(1);
            end
            if (cmd.do_insert) begin
                entry_count_reg <= entry_count_reg + ID_W'(1);
            end
            if (cmd.do_insert || cmd.do_hit || cmd.do_full) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.do_insert) begin
            m_user_id_reg    <= UID_W'(entry_count_reg);
            m_is_new_reg     <= 1'b1;
            m_table_full_reg <= 1'b0;
        end else if (cmd.do_hit) begin
            m_user_id_reg    <= UID_W'(id_rdata - ID_W'(1));
            m_is_new_reg     <= 1'b0;
            m_table_full_reg <= 1'b0;
        end else if (cmd.do_full) begin
            m_user_id_reg    <= '0;
            m_is_new_reg     <= 1'b0;
            m_table_full_reg <= 1'b1;
        end
    end

    assign sts.clear_done = &clr_addr_reg;
    assign sts.id_empty   = (id_rdata == '0);
    assign sts.key_match  = (key_rdata == key_reg);
    assign sts.probe_last = &probe_cnt_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_user_id    = m_user_id_reg;
    assign m_is_new     = m_is_new_reg;
    assign m_table_full = m_table_full_reg;

endmodule

`default_nettype wire

### rtl/hka_ctrl.sv
// controller state machine: clearing pass, accept, probe read and compare
// depends on hka_pkg and hash_key_id_assigner_macros.svh
`default_nettype none
`include "hash_key_id_assigner_macros.svh"

module hka_ctrl import hka_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output hka_cmd_t      cmd,
    input  wire hka_sts_t sts
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.id_empty) begin
                    if (sts.out_free) begin
                        cmd.do_insert = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else if (sts.key_match) begin
                    if (sts.out_free) begin
                        cmd.do_hit = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (sts.probe_last) begin
                    if (sts.out_free) begin
                        cmd.do_full = 1'b1;
                        state_next  = S_IDLE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    `HKA_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd))
    `HKA_ASSERT_IMP(a_result_when_free, cmd.do_insert || cmd.do_hit || cmd.do_full, sts.out_free)
    `HKA_ASSERT_NXT(a_load_then_read, cmd.load, state_reg == S_READ)

endmodule

`default_nettype wire
